>>> src/hpe_pkg.sv
package hpe_pkg;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_DATA  = 2'd1,
    OP_FLAG  = 2'd2,
    OP_CLOSE = 2'd3
  } op_t;

  localparam logic [7:0]  FLAG_BYTE       = 8'h7e;
  localparam logic [2:0]  STUFF_LIMIT     = 3'd6;
  localparam logic [12:0] BIT_TICKS_RESET = 13'd409;
  localparam logic [14:0] DURATION_MAX    = 15'h7fff;
  localparam int          QUEUE_DEPTH     = 2;
  localparam int          MAX_PULSES      = 8;

  typedef struct packed {
    logic [2:0] run;
    logic       lvl;
  } pulse_t;

  // One accepted item: its pulses in order and the index of the final one
  typedef struct packed {
    pulse_t [MAX_PULSES-1:0] pulses;
    logic [2:0]              last_idx;
  } entry_t;

endpackage

>>> src/hpe_front.sv
module hpe_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic [1:0]      s_tuser,
  input  logic            q_ready,
  output logic            q_valid,
  output hpe_pkg::entry_t q_entry
);
  import hpe_pkg::*;

  logic [2:0] run_length;
  logic       line_level;
  logic [2:0] run_next;
  logic       level_next;
  logic [7:0] byte_v;
  logic       stuff;
  logic [3:0] n;
  logic       accept;

  assign s_tready = q_ready;
  assign accept   = s_tvalid && q_ready;

  always_comb begin
    run_next   = run_length;
    level_next = line_level;
    byte_v     = FLAG_BYTE;
    stuff      = 1'b0;
    n          = '0;
    q_entry    = '0;
    case (op_t'(s_tuser))
      OP_OPEN: begin
        run_next   = 3'd1;
        level_next = 1'b1;
      end
      OP_DATA: begin
        byte_v = s_tdata;
        stuff  = 1'b1;
      end
      default: ;
    endcase
    for (int k = 0; k < 8; k++) begin
      if (byte_v[k]) begin
        run_next = run_next + 3'd1;
      end
      if (!byte_v[k] || (stuff && run_next >= STUFF_LIMIT)) begin
        q_entry.pulses[n[2:0]] = '{run: run_next, lvl: level_next};
        n          = n + 4'd1;
        run_next   = 3'd1;
        level_next = ~level_next;
      end
    end
    if (op_t'(s_tuser) == OP_CLOSE) begin
      // end mark: zero duration at level 0
      q_entry.pulses[n[2:0]] = '{run: 3'd0, lvl: 1'b0};
      n = n + 4'd1;
    end
    q_entry.last_idx = 3'(n - 4'd1);
    q_valid = s_tvalid && (n != 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length <= 3'd1;
      line_level <= 1'b1;
    end else if (accept) begin
      run_length <= run_next;
      line_level <= level_next;
    end
  end

endmodule

>>> src/hpe_queue.sv
module hpe_queue #(
  parameter int DEPTH = hpe_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  hpe_pkg::entry_t wr_entry,
  output logic            rd_valid,
  input  logic            rd_pop,
  output hpe_pkg::entry_t rd_entry
);
  import hpe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t         mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> src/hpe_back.sv
module hpe_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [12:0]     cfg_data,
  input  logic            q_valid,
  output logic            q_pop,
  input  hpe_pkg::entry_t q_entry,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [15:0]     m_tdata,
  output logic            m_tlast
);
  import hpe_pkg::*;

  logic [12:0] bit_ticks;
  logic [2:0]  idx;
  logic [14:0] duration;
  logic        level;
  logic        load;
  pulse_t      cur;
  logic [15:0] prod;
  logic        at_last;

  assign cfg_ready = 1'b1;
  assign load      = q_valid && (!m_tvalid || m_tready);
  assign cur       = q_entry.pulses[idx];
  assign prod      = 16'(cur.run) * 16'(bit_ticks);
  assign at_last   = (idx == q_entry.last_idx);
  assign q_pop     = load && at_last;
  assign m_tdata   = {level, duration};

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks <= BIT_TICKS_RESET;
      idx       <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        bit_ticks <= cfg_data;
      end
      if (load) begin
        idx      <= at_last ? 3'd0 : idx + 3'd1;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      duration <= prod[15] ? DURATION_MAX : prod[14:0];
      level    <= cur.lvl;
      m_tlast  <= at_last;
    end
  end

endmodule

>>> src/hdlc_nrzi_pulse_encoder_unit.sv
// Channel | Dir | tdata / data            | tuser     | tlast
// s_      | in  | [7:0] data_byte         | operation | -
// m_      | out | [14:0] duration,[15] lvl| -         | last pulse of item
// cfg_    | in  | [12:0] bit_ticks        | -         | -
//
// An item is classified in the cycle it is accepted; its pulses are queued and
// leave one per cycle while the output is not stalled (1 to 8 per data byte).
// The input takes one item per cycle while the queue has room.
// rst is synchronous; it restores run 1, level 1 and bit_ticks 409.
// Either side may stall independently; the queue decouples them.
module hdlc_nrzi_pulse_encoder_unit #(
  parameter int QUEUE_DEPTH = hpe_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [14:0] duration, [15] level
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);
  import hpe_pkg::*;

  logic   fq_valid;
  logic   fq_ready;
  entry_t fq_entry;
  logic   bq_valid;
  logic   bq_pop;
  entry_t bq_entry;

  hpe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_ready  (fq_ready),
    .q_valid  (fq_valid),
    .q_entry  (fq_entry)
  );

  hpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_entry (fq_entry),
    .rd_valid (bq_valid),
    .rd_pop   (bq_pop),
    .rd_entry (bq_entry)
  );

  hpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (bq_valid),
    .q_pop     (bq_pop),
    .q_entry   (bq_entry),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
